>>> design/plb_pkg.sv
// Shared types and codes for the positional list buffer.
package plb_pkg;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int EIDX_W   = 5;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  typedef logic [1:0] cell_op_t;
  localparam cell_op_t OP_HOLD  = 2'd0;
  localparam cell_op_t OP_LOAD  = 2'd1;
  localparam cell_op_t OP_LEFT  = 2'd2;
  localparam cell_op_t OP_RIGHT = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [EIDX_W-1:0]       entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic                    last;
  } out_item_t;

endpackage

>>> design/plb_cell.sv
// One storage cell of the list chain: hold, load, or take a neighbor's value.
module plb_cell (
  input  logic                             clk,
  input  plb_pkg::cell_op_t                op,
  input  logic signed [plb_pkg::VAL_W-1:0] new_val,
  input  logic signed [plb_pkg::VAL_W-1:0] left_val,
  input  logic signed [plb_pkg::VAL_W-1:0] right_val,
  output logic signed [plb_pkg::VAL_W-1:0] val_r
);
  import plb_pkg::*;

  logic signed [VAL_W-1:0] val_nxt;

  always_comb begin
    case (op)
      OP_LOAD:  val_nxt = new_val;
      OP_LEFT:  val_nxt = left_val;
      OP_RIGHT: val_nxt = right_val;
      default:  val_nxt = val_r;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

>>> design/positional_list_buffer.sv
// Top level of the positional list buffer: cell chain, command control, result register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   in_     | input     | in_valid/in_stall  | in_data   (cmd, position, value)
//   out_    | output    | out_valid/out_stall| out_data  (status, entry_index,
//           |           |                    |            entry_value, last)
//
// Append, push, insert and delete update the cell chain on the edge that accepts them;
// their single result, like that of every error, lands in the output register on the same edge.
// A list of N entries streams N results, one per cycle while out_stall is low, by
// rotating the first N cells toward the head; after N steps the chain is back in order.
// rst_n (synchronous, active low) empties the list; cell contents are not cleared.
// in_stall is high while a list streams or while a result sits stalled at out_.
module positional_list_buffer #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  plb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output plb_pkg::out_item_t out_data
);
  import plb_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);            // entry count width
  localparam int IW = $clog2(DEPTH);                // list position width
  localparam int WW = (CW > POS_W) ? CW : POS_W;    // compare width

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic                    state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [IW-1:0]           list_idx_r, list_idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  logic signed [VAL_W-1:0] cell_val [DEPTH];
  cell_op_t                cell_op  [DEPTH];
  logic signed [VAL_W-1:0] new_val;

  logic                    slot_free;
  logic                    accept;
  logic                    list_step;
  logic                    list_last;
  logic                    do_ins, do_del, start_list;
  logic [STATUS_W-1:0]     status;
  logic [WW-1:0]           pos_eff;
  logic [WW-1:0]           count_ext;
  logic                    full;
  logic                    is_ins;

  // Output slot frees when empty or when its result transfers this cycle.
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !slot_free;
  assign accept    = in_valid && !in_stall;
  assign list_step = (state_r == S_LIST) && slot_free;
  assign list_last = ((CW'(list_idx_r) + CW'(1)) == count_r);

  assign count_ext = WW'(count_r);
  assign full      = (count_r == CW'(DEPTH));

  // Decode the command and pick status; errors leave the chain untouched.
  always_comb begin
    pos_eff    = WW'(in_data.position);
    is_ins     = 1'b0;
    status     = ST_OK;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    start_list = 1'b0;
    unique case (in_data.cmd)
      CMD_APPEND: begin
        pos_eff = count_ext;
        is_ins  = 1'b1;
      end
      CMD_PUSH: begin
        pos_eff = '0;
        is_ins  = 1'b1;
      end
      CMD_INSERT: begin
        is_ins = 1'b1;
      end
      CMD_DELETE: begin
        if (pos_eff >= count_ext) begin
          status = ST_RANGE;
        end else begin
          do_del = 1'b1;
        end
      end
      CMD_LIST: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else begin
          start_list = 1'b1;
        end
      end
      default: begin
        status = ST_OK;   // unused codes: no-op
      end
    endcase
    if (is_ins) begin
      if (full) begin
        status = ST_FULL;
      end else if (pos_eff > count_ext) begin
        status = ST_RANGE;
      end else begin
        do_ins = 1'b1;
      end
    end
  end

  // During a list step the tail slot of the live list takes the old head.
  assign new_val = list_step ? cell_val[0] : in_data.value;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [VAL_W-1:0] left_v, right_v;

      if (gi == 0) begin : g_head
        assign left_v = new_val;          // never selected
      end else begin : g_mid_l
        assign left_v = cell_val[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign right_v = cell_val[gi];    // nothing beyond the last cell
      end else begin : g_mid_r
        assign right_v = cell_val[gi+1];
      end

      // Insert: load at the position, move later cells back by one.
      // Delete: pull later cells forward over the position.
      // List: rotate the live entries one step toward the head.
      always_comb begin
        cell_op[gi] = OP_HOLD;
        if (accept && do_ins) begin
          if (WW'(gi) == pos_eff) begin
            cell_op[gi] = OP_LOAD;
          end else if (WW'(gi) > pos_eff) begin
            cell_op[gi] = OP_LEFT;
          end
        end else if (accept && do_del) begin
          if (WW'(gi) >= pos_eff) begin
            cell_op[gi] = OP_RIGHT;
          end
        end else if (list_step) begin
          if (CW'(gi + 1) == count_r) begin
            cell_op[gi] = OP_LOAD;
          end else begin
            cell_op[gi] = OP_RIGHT;
          end
        end
      end

      plb_cell u_cell (
        .clk       (clk),
        .op        (cell_op[gi]),
        .new_val   (new_val),
        .left_val  (left_v),
        .right_val (right_v),
        .val_r     (cell_val[gi])
      );
    end
  endgenerate

  // Sequencer, count and result register.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    list_idx_nxt  = list_idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // drop a result once it transfers
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (do_ins) begin
            count_nxt = count_r + CW'(1);
          end else if (do_del) begin
            count_nxt = count_r - CW'(1);
          end
          if (start_list) begin
            state_nxt    = S_LIST;
            list_idx_nxt = '0;
          end else begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.status      = status;
            out_data_nxt.entry_index = '0;
            out_data_nxt.entry_value = '0;
            out_data_nxt.last        = 1'b1;
          end
        end
      end
      S_LIST: begin
        if (list_step) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = ST_OK;
          out_data_nxt.entry_index = EIDX_W'(list_idx_r);
          out_data_nxt.entry_value = cell_val[0];
          out_data_nxt.last        = list_last;
          if (list_last) begin
            state_nxt = S_IDLE;
          end else begin
            list_idx_nxt = list_idx_r + IW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      list_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      list_idx_r  <= list_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold payload, no reset needed
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
